// ----- hdl/tcu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the timer compare and interrupt unit.
package tcu_pkg;

	localparam int CNT_W = 16;
	localparam int VEC_W = 4;
	localparam int FLAG_W = 3;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_WR_CTRL   = 3'd1;
	localparam logic [2:0] OP_WR_COUNT  = 3'd2;
	localparam logic [2:0] OP_WR_CMP    = 3'd3;
	localparam logic [2:0] OP_WR_CCTL   = 3'd4;
	localparam logic [2:0] OP_RD_VECTOR = 3'd5;
	localparam logic [2:0] OP_DONE0     = 3'd6;
	localparam logic [2:0] OP_DONE1     = 3'd7;

	localparam logic [1:0] MODE_STOP   = 2'd0;
	localparam logic [1:0] MODE_UP     = 2'd1;
	localparam logic [1:0] MODE_CONT   = 2'd2;
	localparam logic [1:0] MODE_UPDOWN = 2'd3;

	localparam logic [VEC_W-1:0] VEC_NONE = 4'd0;
	localparam logic [VEC_W-1:0] VEC_OVF  = 4'd10;

	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       chan_index;
		logic [CNT_W-1:0] wdata;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count_value;
		logic [VEC_W-1:0]  vector_value;
		logic              irq_zero;
		logic              irq_shared;
		logic              overflow_flag;
		logic [FLAG_W-1:0] channel_flags;
	} out_t;

endpackage

// ----- hdl/tcu_core.sv -----
`timescale 1ns / 1ps
// Timer state registers and the per-word update and result logic.
module tcu_core #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  tcu_pkg::in_t  item,
	output tcu_pkg::out_t res
);

	logic [tcu_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]                mode_q, mode_n;
	logic                      ovf_en_q, ovf_en_n;
	logic                      ovf_q, ovf_n;
	logic [tcu_pkg::CNT_W-1:0] cmp_q [NUM_CHANNELS];
	logic [tcu_pkg::CNT_W-1:0] cmp_n [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]   en_q, en_n;
	logic [NUM_CHANNELS-1:0]   pend_q, pend_n;

	always_comb begin
		logic                      found;
		logic                      irq_z;
		logic                      irq_s;
		logic [tcu_pkg::VEC_W-1:0] vec;
		logic [tcu_pkg::FLAG_W-1:0] flags;

		cnt_n    = cnt_q;
		mode_n   = mode_q;
		ovf_en_n = ovf_en_q;
		ovf_n    = ovf_q;
		cmp_n    = cmp_q;
		en_n     = en_q;
		pend_n   = pend_q;
		found    = 1'b0;
		irq_z    = 1'b0;
		irq_s    = 1'b0;
		vec      = tcu_pkg::VEC_NONE;
		flags    = '0;

		unique case (item.op)
			tcu_pkg::OP_TICK: begin
				if (mode_q == tcu_pkg::MODE_UP) begin
					if (cmp_q[0] != '0) begin
						if (cnt_q == cmp_q[0]) begin
							// period reached: wrap to zero
							cnt_n = '0;
							if (ovf_en_q) begin
								ovf_n = 1'b1;
								irq_s = 1'b1;
							end
						end else begin
							cnt_n = cnt_q + 1'b1;
							if (en_q[0] && cnt_n == cmp_q[0]) begin
								pend_n[0] = 1'b1;
								irq_z     = 1'b1;
							end
						end
						for (int i = 1; i < NUM_CHANNELS; i++) begin
							if (en_q[i] && cmp_q[i] == cnt_n) begin
								pend_n[i] = 1'b1;
								irq_s     = 1'b1;
							end
						end
					end
				end else if (mode_q == tcu_pkg::MODE_CONT ||
					     mode_q == tcu_pkg::MODE_UPDOWN) begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			tcu_pkg::OP_WR_CTRL: begin
				ovf_n    = item.wdata[0];
				ovf_en_n = item.wdata[1];
				mode_n   = item.wdata[5:4];
				if (item.wdata[2]) begin
					cnt_n = '0;
				end
			end
			tcu_pkg::OP_WR_COUNT: begin
				cnt_n = item.wdata;
			end
			tcu_pkg::OP_WR_CMP: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (32'(item.chan_index) == i) begin
						cmp_n[i] = item.wdata;
					end
				end
			end
			tcu_pkg::OP_WR_CCTL: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (32'(item.chan_index) == i) begin
						pend_n[i] = item.wdata[0];
						en_n[i]   = item.wdata[4];
					end
				end
			end
			tcu_pkg::OP_RD_VECTOR: begin
				// lowest pending shared channel wins, overflow last
				for (int i = 1; i < NUM_CHANNELS; i++) begin
					if (!found && pend_q[i]) begin
						found     = 1'b1;
						pend_n[i] = 1'b0;
						vec       = tcu_pkg::VEC_W'(2 * i);
					end
				end
				if (!found && ovf_en_q && ovf_q) begin
					ovf_n = 1'b0;
					vec   = tcu_pkg::VEC_OVF;
				end
			end
			tcu_pkg::OP_DONE0: begin
				pend_n[0] = 1'b0;
			end
			tcu_pkg::OP_DONE1: begin
				irq_s = (|pend_q[NUM_CHANNELS-1:1]) || (ovf_en_q && ovf_q);
			end
			default: begin
				cnt_n = cnt_q;
			end
		endcase

		for (int i = 0; i < tcu_pkg::FLAG_W; i++) begin
			if (i < NUM_CHANNELS) begin
				flags[i] = pend_n[i];
			end
		end

		res.count_value   = cnt_n;
		res.vector_value  = vec;
		res.irq_zero      = irq_z;
		res.irq_shared    = irq_s;
		res.overflow_flag = ovf_n;
		res.channel_flags = flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			mode_q   <= tcu_pkg::MODE_STOP;
			ovf_en_q <= 1'b0;
			ovf_q    <= 1'b0;
			en_q     <= '0;
			pend_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cmp_q[i] <= '0;
			end
		end else if (fire) begin
			cnt_q    <= cnt_n;
			mode_q   <= mode_n;
			ovf_en_q <= ovf_en_n;
			ovf_q    <= ovf_n;
			en_q     <= en_n;
			pend_q   <= pend_n;
			cmp_q    <= cmp_n;
		end
	end

endmodule

// ----- hdl/tcu_rbuf.sv -----
`timescale 1ns / 1ps
// Two-entry result buffer that decouples the output stall from the input side.
module tcu_rbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcu_pkg::out_t push_data,
	output logic          full,
	output logic          valid,
	input  logic          stall,
	output tcu_pkg::out_t data
);

	tcu_pkg::out_t q0_q, q1_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign data  = q0_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload: head takes the new word when it is free or drains this cycle
	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			q0_q <= q1_q;
		end else if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			q0_q <= push_data;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			q1_q <= push_data;
		end
	end

endmodule

// ----- hdl/timer_compare_interrupt_unit.sv -----
`timescale 1ns / 1ps
// Top level of the timer compare and interrupt unit.
// Each input word (tick, register write, vector read or interrupt-done) is
// captured in an input register and applied to the timer state when the
// output buffer has room; its result word is written to the two-entry
// output buffer as it is applied, so one word is taken every cycle while
// the input does not stall. The input stalls only while the input register
// is full and the output buffer holds two unread words; the output stall
// never reaches the input within the same cycle.
module timer_compare_interrupt_unit #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  tcu_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output tcu_pkg::out_t result
);

	tcu_pkg::in_t  item_s1;
	logic          valid_s1;
	logic          buf_full;
	logic          take;
	logic          advance;
	tcu_pkg::out_t res;

	assign item_stall = valid_s1 && buf_full;
	assign take       = item_valid && !item_stall;
	assign advance    = valid_s1 && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	tcu_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res)
	);

	tcu_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.full      (buf_full),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result)
	);

endmodule

// ----- hdl/tcu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the timer compare and interrupt unit, with its bind.
module tcu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          item_stall,
	input logic          result_valid,
	input logic          result_stall,
	input tcu_pkg::out_t result
);

	// hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed or dropped");

	// with no result waiting, the input side must not stall
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty output");

	// a vector is even and no higher than the overflow code
	a_vector_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !result.vector_value[0] &&
			result.vector_value <= tcu_pkg::VEC_OVF)
		else $error("vector out of range");

	// a channel-zero request always leaves its flag set
	a_irq_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.irq_zero |-> result.channel_flags[0])
		else $error("channel-zero request without its flag");

endmodule

bind timer_compare_interrupt_unit tcu_checker u_tcu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
